@@ sv/imvm_pkg.sv @@
// ----------------------------------------------------------------------------
// imvm_pkg
// Shared types and constants for the iterated matrix-vector multiplier.
// ----------------------------------------------------------------------------
package imvm_pkg;

  localparam int MAX_DIM   = 64;
  localparam int IDX_W     = 6;
  localparam int DIM_W     = 7;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 64;
  localparam int ACC_W     = 72;
  localparam int ADDR_W    = 12;
  localparam int PASS_W    = 16;
  localparam int CFG_W     = 16;
  localparam int FRAC_BITS = 16;

  localparam logic [1:0] CMD_MATRIX = 2'd0;
  localparam logic [1:0] CMD_VECTOR = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;

  localparam logic [1:0] CFG_DIMENSION = 2'd0;
  localparam logic [1:0] CFG_PASSES    = 2'd1;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic shift_x;
    logic shift_y;
    logic copy;
  } cell_ctrl_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_flags_t;

endpackage

@@ sv/iterated_matrix_vector_multiply.sv @@
// A load transaction is accepted every cycle while idle. In a run, each row streams n matrix
// words from the single-write, single-read matrix RAM through the multiply-accumulate
// pipeline, then drains. Emission follows at one result per cycle while the receiver is
// ready, n results; a pass that leaves the vector unchanged ends the run early. Reset
// clears control state and sets dimension 64 and one pass; matrix and vector contents are
// undefined until loaded.
// ----------------------------------------------------------------------------
// iterated_matrix_vector_multiply
// Repeated fixed-point matrix-vector product over a ring of vector cells.
// ----------------------------------------------------------------------------
module iterated_matrix_vector_multiply (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic [5:0]                    row_i,
  input  logic [5:0]                    col_i,
  input  logic signed [31:0]            value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [5:0]                    index_o,
  output logic signed [31:0]            element_o,
  output logic                          saturated_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [imvm_pkg::CFG_W-1:0]    cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_PASS,
    ST_EMIT
  } state_e;

  state_e                            state_q;
  logic [imvm_pkg::DIM_W-1:0]        dim_q, n_q, n_eff;
  logic [imvm_pkg::PASS_W-1:0]       passes_q, pass_cnt_q;
  logic [imvm_pkg::IDX_W-1:0]        row_q, col_q, emit_q, last_idx;
  logic                              sat_q, eq_q;
  logic [imvm_pkg::DATA_W-1:0]       xi_q, x_d1_q;
  imvm_pkg::mac_flags_t              flags1_q;
  logic                              out_valid_q, out_sat_q, out_last_q;
  logic [imvm_pkg::IDX_W-1:0]        out_index_q;
  logic [imvm_pkg::DATA_W-1:0]       out_elem_q;

  logic                              in_acc, emit_load, mac_issue;
  imvm_pkg::cell_ctrl_t              ctrl;
  logic [imvm_pkg::DATA_W-1:0]       x_cell [imvm_pkg::MAX_DIM];
  logic [imvm_pkg::DATA_W-1:0]       y_cell [imvm_pkg::MAX_DIM];
  logic [imvm_pkg::DATA_W-1:0]       x_head, ram_rdata, mac_result;
  logic                              mac_done, mac_sat;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign last_idx    = imvm_pkg::IDX_W'(n_q - 7'd1);
  assign x_head      = x_cell[0];
  assign mac_issue   = (state_q == ST_MAC);
  assign emit_load   = (state_q == ST_EMIT) & (~out_valid_q | out_ready_i);

  always_comb begin
    if (dim_q == '0) begin
      n_eff = 7'd1;
    end else if (dim_q > imvm_pkg::DIM_W'(imvm_pkg::MAX_DIM)) begin
      n_eff = imvm_pkg::DIM_W'(imvm_pkg::MAX_DIM);
    end else begin
      n_eff = dim_q;
    end
  end

  always_comb begin
    ctrl.shift_x = mac_issue | emit_load;
    ctrl.shift_y = (state_q == ST_DRAIN) & mac_done;
    ctrl.copy    = (state_q == ST_PASS) & ~eq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q    <= imvm_pkg::DIM_W'(imvm_pkg::MAX_DIM);
      passes_q <= 16'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        imvm_pkg::CFG_DIMENSION: dim_q    <= cfg_data_i[imvm_pkg::DIM_W-1:0];
        imvm_pkg::CFG_PASSES:    passes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer: rows, passes, emission, and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= imvm_pkg::DIM_W'(imvm_pkg::MAX_DIM);
      pass_cnt_q  <= '0;
      row_q       <= '0;
      col_q       <= '0;
      emit_q      <= '0;
      sat_q       <= 1'b0;
      eq_q        <= 1'b1;
      out_valid_q <= 1'b0;
      out_sat_q   <= 1'b0;
      out_last_q  <= 1'b0;
      out_index_q <= '0;
      out_elem_q  <= '0;
    end else begin
      if (out_valid_q & out_ready_i & ~emit_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && cmd_i == imvm_pkg::CMD_RUN) begin
            n_q        <= n_eff;
            sat_q      <= 1'b0;
            eq_q       <= 1'b1;
            row_q      <= '0;
            col_q      <= '0;
            emit_q     <= '0;
            pass_cnt_q <= '0;
            state_q    <= (passes_q == '0) ? ST_EMIT : ST_MAC;
          end
        end
        ST_MAC: begin
          if (col_q == last_idx) begin
            col_q   <= '0;
            state_q <= ST_DRAIN;
          end else begin
            col_q <= col_q + 6'd1;
          end
        end
        ST_DRAIN: begin
          if (mac_done) begin
            sat_q <= sat_q | mac_sat;
            eq_q  <= eq_q & (mac_result == xi_q);
            if (row_q == last_idx) begin
              row_q   <= '0;
              state_q <= ST_PASS;
            end else begin
              row_q   <= row_q + 6'd1;
              state_q <= ST_MAC;
            end
          end
        end
        ST_PASS: begin
          if (eq_q || (pass_cnt_q + 16'd1 == passes_q)) begin
            state_q <= ST_EMIT;
          end else begin
            pass_cnt_q <= pass_cnt_q + 16'd1;
            eq_q       <= 1'b1;
            state_q    <= ST_MAC;
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            out_valid_q <= 1'b1;
            out_index_q <= emit_q;
            out_elem_q  <= x_head;
            out_sat_q   <= sat_q;
            out_last_q  <= (emit_q == last_idx);
            if (emit_q == last_idx) begin
              state_q <= ST_IDLE;
            end else begin
              emit_q <= emit_q + 6'd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // First multiplier stage: vector element aligned with the RAM read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags1_q <= '0;
    end else begin
      flags1_q.valid <= mac_issue;
      flags1_q.first <= mac_issue & (col_q == '0);
      flags1_q.last  <= mac_issue & (col_q == last_idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mac_issue) begin
      x_d1_q <= x_head;
      if (col_q == row_q) begin
        xi_q <= x_head;
      end
    end
  end

  imvm_ram #(
    .WIDTH(imvm_pkg::DATA_W),
    .DEPTH(imvm_pkg::MAX_DIM * imvm_pkg::MAX_DIM)
  ) u_matrix (
    .clk_i  (clk_i),
    .we_i   (in_acc && cmd_i == imvm_pkg::CMD_MATRIX),
    .waddr_i({row_i, col_i}),
    .wdata_i(value_i),
    .re_i   (mac_issue),
    .raddr_i({row_q, col_q}),
    .rdata_o(ram_rdata)
  );

  imvm_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags1_q),
    .a_i     (ram_rdata),
    .b_i     (x_d1_q),
    .done_o  (mac_done),
    .result_o(mac_result),
    .sat_o   (mac_sat)
  );

  for (genvar k = 0; k < imvm_pkg::MAX_DIM; k++) begin : g_cell
    localparam logic [imvm_pkg::IDX_W-1:0] K = imvm_pkg::IDX_W'(k);
    localparam int NXT = (k + 1) % imvm_pkg::MAX_DIM;
    imvm_pkg::cell_ctrl_t cell_ctrl;
    // Cells past the active length keep their contents through a run.
    assign cell_ctrl = (K <= last_idx) ? ctrl : '0;
    imvm_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .tail_i     (K == last_idx),
      .load_i     (in_acc && cmd_i == imvm_pkg::CMD_VECTOR && col_i == K),
      .load_data_i(value_i),
      .x_next_i   (x_cell[NXT]),
      .x_wrap_i   (x_head),
      .y_next_i   (y_cell[NXT]),
      .y_wrap_i   (mac_result),
      .x_o        (x_cell[k]),
      .y_o        (y_cell[k])
    );
  end

  assign out_valid_o = out_valid_q;
  assign index_o     = out_index_q;
  assign element_o   = out_elem_q;
  assign saturated_o = out_sat_q;
  assign last_o      = out_last_q;

`ifndef SYNTHESIS
  a_out_held_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(index_o) && $stable(element_o)))
    else $error("waiting result changed before acceptance");

  a_mac_done_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == ST_DRAIN))
    else $error("dot product finished outside drain");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_load && emit_q == last_idx) |=> (state_q == ST_IDLE && last_o))
    else $error("final element did not end emission");
`endif

endmodule

@@ sv/imvm_ram.sv @@
// ----------------------------------------------------------------------------
// imvm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/imvm_cell.sv @@
// ----------------------------------------------------------------------------
// imvm_cell
// One vector cell: holds a current element and a next-pass element.
// ----------------------------------------------------------------------------
module imvm_cell (
  input  logic                           clk_i,
  input  imvm_pkg::cell_ctrl_t           ctrl_i,
  input  logic                           tail_i,
  input  logic                           load_i,
  input  logic [imvm_pkg::DATA_W-1:0]    load_data_i,
  input  logic [imvm_pkg::DATA_W-1:0]    x_next_i,
  input  logic [imvm_pkg::DATA_W-1:0]    x_wrap_i,
  input  logic [imvm_pkg::DATA_W-1:0]    y_next_i,
  input  logic [imvm_pkg::DATA_W-1:0]    y_wrap_i,
  output logic [imvm_pkg::DATA_W-1:0]    x_o,
  output logic [imvm_pkg::DATA_W-1:0]    y_o
);

  logic [imvm_pkg::DATA_W-1:0] x_q, x_d, y_q, y_d;

  // The tail cell closes the ring at the active length.
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (load_i) begin
      x_d = load_data_i;
    end else if (ctrl_i.copy) begin
      x_d = y_q;
    end else if (ctrl_i.shift_x) begin
      x_d = tail_i ? x_wrap_i : x_next_i;
    end
    if (ctrl_i.shift_y) begin
      y_d = tail_i ? y_wrap_i : y_next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

@@ sv/imvm_mac.sv @@
// ----------------------------------------------------------------------------
// imvm_mac
// Multiply-accumulate unit with scaling and saturation of the dot product.
// ----------------------------------------------------------------------------
module imvm_mac (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  imvm_pkg::mac_flags_t          flags_i,
  input  logic [imvm_pkg::DATA_W-1:0]   a_i,
  input  logic [imvm_pkg::DATA_W-1:0]   b_i,
  output logic                          done_o,
  output logic [imvm_pkg::DATA_W-1:0]   result_o,
  output logic                          sat_o
);

  imvm_pkg::mac_flags_t              flags_q;
  logic [imvm_pkg::PROD_W-1:0]       prod_q;
  logic [imvm_pkg::ACC_W-1:0]        acc_q, acc_d, prod_ext;
  logic                              done_q;
  logic [imvm_pkg::ACC_W-1:0]        scaled;
  logic [imvm_pkg::ACC_W-32:0]       top;
  logic                              fits;

  assign prod_ext = {{(imvm_pkg::ACC_W - imvm_pkg::PROD_W){prod_q[imvm_pkg::PROD_W-1]}},
                     prod_q};
  assign acc_d    = flags_q.first ? prod_ext : acc_q + prod_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      done_q  <= 1'b0;
    end else begin
      flags_q <= flags_i;
      done_q  <= flags_q.valid & flags_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= imvm_pkg::PROD_W'($signed(a_i) * $signed(b_i));
    if (flags_q.valid) begin
      acc_q <= acc_d;
    end
  end

  // The arithmetic shift rounds toward minus infinity.
  assign scaled   = $signed(acc_q) >>> imvm_pkg::FRAC_BITS;
  assign top      = scaled[imvm_pkg::ACC_W-1:31];
  assign fits     = (&top) | (~|top);
  assign result_o = fits ? scaled[imvm_pkg::DATA_W-1:0]
                         : (acc_q[imvm_pkg::ACC_W-1] ? imvm_pkg::SAT_MIN : imvm_pkg::SAT_MAX);
  assign sat_o    = ~fits;
  assign done_o   = done_q;

endmodule

@@ tb/tb_iterated_matrix_vector_multiply.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_iterated_matrix_vector_multiply
// Self-checking bench: loads matrices and vectors, issues runs under several
// dimension and pass settings, and compares every emitted element against an
// in-bench fixed-point predictor with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_iterated_matrix_vector_multiply;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic [5:0]  idx;
    logic [31:0] elem;
    logic        sat;
    logic        last;
  } vec_elem_t;

  class mvm_scoreboard;
    logic [31:0] mat [imvm_pkg::MAX_DIM*imvm_pkg::MAX_DIM];
    logic [31:0] vec [imvm_pkg::MAX_DIM];
    bit          mat_written [imvm_pkg::MAX_DIM*imvm_pkg::MAX_DIM];
    bit          vec_written [imvm_pkg::MAX_DIM];
    int unsigned dim_reg = 64;
    int unsigned passes  = 1;
    vec_elem_t   expected_elems [$];
    int          errors = 0;

    function int unsigned active_dim();
      if (dim_reg == 0) return 1;
      if (dim_reg > imvm_pkg::MAX_DIM) return imvm_pkg::MAX_DIM;
      return dim_reg;
    endfunction

    function void write_reg(logic [1:0] idx, logic [imvm_pkg::CFG_W-1:0] data);
      if (idx == imvm_pkg::CFG_DIMENSION) dim_reg = data[imvm_pkg::DIM_W-1:0];
      else if (idx == imvm_pkg::CFG_PASSES) passes = data[imvm_pkg::PASS_W-1:0];
    endfunction

    // Dot product of one row with the current vector, scaled and saturated.
    function logic [31:0] row_product(int r, int n, ref bit sat);
      logic signed [79:0] acc;
      logic signed [79:0] scaled;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [63:0] p;
      acc = '0;
      for (int j = 0; j < n; j++) begin
        a = mat[r*imvm_pkg::MAX_DIM + j];
        b = vec[j];
        p = a * b;
        acc += p;
      end
      scaled = acc >>> imvm_pkg::FRAC_BITS;
      if (scaled > 80'sd2147483647) begin
        sat = 1;
        return imvm_pkg::SAT_MAX;
      end
      if (scaled < -80'sd2147483648) begin
        sat = 1;
        return imvm_pkg::SAT_MIN;
      end
      return scaled[31:0];
    endfunction

    function void note_input(logic [1:0] cmd, logic [5:0] row, logic [5:0] col,
                             logic [31:0] value);
      int unsigned n;
      bit sat;
      bit same;
      logic [31:0] nxt [imvm_pkg::MAX_DIM];
      vec_elem_t e;
      if (cmd == imvm_pkg::CMD_MATRIX) begin
        mat[row*imvm_pkg::MAX_DIM + col] = value;
        mat_written[row*imvm_pkg::MAX_DIM + col] = 1;
      end else if (cmd == imvm_pkg::CMD_VECTOR) begin
        vec[col] = value;
        vec_written[col] = 1;
      end else if (cmd == imvm_pkg::CMD_RUN) begin
        n = active_dim();
        sat = 0;
        for (int unsigned h = 0; h < passes; h++) begin
          for (int i = 0; i < n; i++) nxt[i] = row_product(i, n, sat);
          same = 1;
          for (int i = 0; i < n; i++) if (nxt[i] != vec[i]) same = 0;
          if (same) break;
          for (int i = 0; i < n; i++) vec[i] = nxt[i];
        end
        for (int i = 0; i < n; i++) begin
          e.idx  = i[5:0];
          e.elem = vec[i];
          e.sat  = sat;
          e.last = (i + 1 == n);
          expected_elems.push_back(e);
        end
      end
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [5:0] idx, logic [31:0] elem, logic sat, logic last);
      vec_elem_t e;
      if (expected_elems.size() == 0) begin
        report($sformatf("unexpected element index %0d", idx));
        return;
      end
      e = expected_elems.pop_front();
      if (idx !== e.idx) report($sformatf("index %0d, want %0d", idx, e.idx));
      if (elem !== e.elem)
        report($sformatf("element[%0d] %h, want %h", e.idx, elem, e.elem));
      if (sat !== e.sat)
        report($sformatf("saturated[%0d] %b, want %b", e.idx, sat, e.sat));
      if (last !== e.last)
        report($sformatf("last[%0d] %b, want %b", e.idx, last, e.last));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        cmd_i;
  logic [5:0]        row_i;
  logic [5:0]        col_i;
  logic signed [31:0] value_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [5:0]        index_o;
  logic signed [31:0] element_o;
  logic              saturated_o;
  logic              last_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i;
  logic [imvm_pkg::CFG_W-1:0] cfg_data_i;

  mvm_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_left;
  int quiet_cycles;

  iterated_matrix_vector_multiply dut (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Receiver: random back-pressure, plus a long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      out_ready_i = 1'b0;
      hold_off_left--;
    end else begin
      out_ready_i = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_input(cmd_i, row_i, col_i, value_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(index_o, element_o, saturated_o, last_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function logic [31:0] rand_value();
    // Mostly small Q16.16 values so runs stay meaningful; sometimes any pattern.
    if ($urandom_range(3) == 0) return $urandom;
    return 32'($signed($urandom_range(131071)) - 65536);
  endfunction

  task send(logic [1:0] cmd, logic [5:0] row, logic [5:0] col, logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    cmd_i      = cmd;
    row_i      = row;
    col_i      = col;
    value_i    = value;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task wait_idle();
    while (sb.expected_elems.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task write_cfg(logic [1:0] idx, logic [imvm_pkg::CFG_W-1:0] data);
    wait_idle();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // A run must never read an entry that was not loaded, so fill any gaps first.
  task run_filled();
    int unsigned n;
    n = sb.active_dim();
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (!sb.mat_written[r*imvm_pkg::MAX_DIM + c])
          send(imvm_pkg::CMD_MATRIX, 6'(r), 6'(c), rand_value());
    for (int c = 0; c < n; c++)
      if (!sb.vec_written[c]) send(imvm_pkg::CMD_VECTOR, 6'd0, 6'(c), rand_value());
    send(imvm_pkg::CMD_RUN, 6'($urandom), 6'($urandom), $urandom);
  endtask

  task random_items(int count);
    int unsigned n;
    int k;
    for (int i = 0; i < count; i++) begin
      n = sb.active_dim();
      k = $urandom_range(99);
      if (k < 50)
        send(imvm_pkg::CMD_MATRIX,
             6'(($urandom_range(9) == 0) ? $urandom : $urandom_range(n - 1)),
             6'(($urandom_range(9) == 0) ? $urandom : $urandom_range(n - 1)),
             rand_value());
      else if (k < 78)
        send(imvm_pkg::CMD_VECTOR, 6'($urandom),
             6'(($urandom_range(9) == 0) ? $urandom : $urandom_range(n - 1)),
             rand_value());
      else if (k < 84)
        send(CMD_UNUSED, 6'($urandom), 6'($urandom), $urandom);
      else
        run_filled();
    end
  endtask

  task random_settings();
    write_cfg(imvm_pkg::CFG_DIMENSION, 16'($urandom_range(1, 5)));
    write_cfg(imvm_pkg::CFG_PASSES, 16'($urandom_range(3)));
  endtask

  initial begin
    sb = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cmd_i         = imvm_pkg::CMD_MATRIX;
    row_i         = '0;
    col_i         = '0;
    value_i       = '0;
    out_ready_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = imvm_pkg::CFG_DIMENSION;
    cfg_data_i    = '0;
    hold_off_left = 0;
    quiet_cycles  = 0;
    send_idle_pct = 30;
    recv_idle_pct = 83;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extreme values with saturation, unused command, corner indexes.
    write_cfg(imvm_pkg::CFG_DIMENSION, 16'd4);
    write_cfg(imvm_pkg::CFG_PASSES, 16'd1);
    send(imvm_pkg::CMD_MATRIX, 6'd0, 6'd0, 32'h7FFF_FFFF);
    send(imvm_pkg::CMD_MATRIX, 6'd3, 6'd3, 32'h8000_0000);
    send(imvm_pkg::CMD_MATRIX, 6'd63, 6'd63, 32'hFFFF_FFFF);
    send(imvm_pkg::CMD_VECTOR, 6'd63, 6'd0, 32'h7FFF_FFFF);
    send(imvm_pkg::CMD_VECTOR, 6'd0, 6'd63, 32'h0000_0001);
    send(CMD_UNUSED, 6'd63, 6'd63, 32'hFFFF_FFFF);
    run_filled();
    // Zero passes emit the stored vector untouched.
    write_cfg(imvm_pkg::CFG_PASSES, 16'd0);
    send(imvm_pkg::CMD_RUN, 6'd0, 6'd0, 32'd0);
    // Identity matrix: the first pass changes nothing, so the long run ends early.
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        send(imvm_pkg::CMD_MATRIX, 6'(r), 6'(c), (r == c) ? 32'h0001_0000 : 32'h0);
    write_cfg(imvm_pkg::CFG_PASSES, 16'hFFFF);
    send(imvm_pkg::CMD_RUN, 6'd0, 6'd0, 32'd0);
    // Dimension zero behaves as one.
    write_cfg(imvm_pkg::CFG_DIMENSION, 16'd0);
    send(imvm_pkg::CMD_RUN, 6'd0, 6'd0, 32'd0);

    random_settings();
    // Long receiver hold-off while a run and more loads keep coming in.
    run_filled();
    hold_off_left = 300;
    random_items(20);

    send_idle_pct = 83;
    recv_idle_pct = 30;
    random_settings();
    random_items(20);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_settings();
    random_items(20);

    wait_idle();
    if (sb.errors == 0 && sb.expected_elems.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
